FILE: hdl/sitoa_pkg.sv
package sitoa_pkg;

  localparam int unsigned MAG_W = 32;
  localparam int unsigned MAX_DIGITS = 10;
  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  // One classified item: sign, unsigned magnitude and its digit count
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [3:0]       ndig;
  } sitoa_item_t;

  // Power of ten for a digit position, 10^0 .. 10^9
  function automatic logic [MAG_W-1:0] pow10(input logic [3:0] pos);
    logic [MAG_W-1:0] p;
    case (pos)
      4'd0:    p = 32'd1;
      4'd1:    p = 32'd10;
      4'd2:    p = 32'd100;
      4'd3:    p = 32'd1000;
      4'd4:    p = 32'd10000;
      4'd5:    p = 32'd100000;
      4'd6:    p = 32'd1000000;
      4'd7:    p = 32'd10000000;
      4'd8:    p = 32'd100000000;
      4'd9:    p = 32'd1000000000;
      default: p = 32'd1;
    endcase
    return p;
  endfunction

endpackage

FILE: hdl/sitoa_front.sv
module sitoa_front
  import sitoa_pkg::*;
(
  input  logic [31:0] in_value,
  output sitoa_item_t item
);

  logic             neg;
  logic [MAG_W-1:0] mag;
  logic [3:0]       ndig;

  // Take the sign and the magnitude; the most negative value maps to 2^31
  assign neg = in_value[31];
  assign mag = neg ? (32'd0 - in_value) : in_value;

  // Count digits: one plus the number of powers 10^1 .. 10^9 not above the magnitude
  always_comb begin
    ndig = 4'd1;
    for (int j = 1; j < MAX_DIGITS; j++) begin
      if (mag >= pow10(4'(j))) begin
        ndig = ndig + 4'd1;
      end
    end
  end

  assign item = '{neg: neg, mag: mag, ndig: ndig};

endmodule

FILE: hdl/sitoa_queue.sv
module sitoa_queue
  import sitoa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  sitoa_item_t wdata,
  output logic        full,
  input  logic        pop,
  output logic        valid,
  output sitoa_item_t rdata
);

  sitoa_item_t mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign rdata = mem_r[rd_ptr_r];

  // Advance pointers and the fill count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: hdl/sitoa_back.sv
module sitoa_back
  import sitoa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  sitoa_item_t q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char_code,
  output logic        out_last_char,
  output logic [3:0]  out_char_count
);

  logic             busy_r, busy_nxt;
  logic             sign_r, sign_nxt;
  logic [MAG_W-1:0] rem_r, rem_nxt;
  logic [3:0]       pos_r, pos_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic             ov_r, ov_nxt;
  logic [7:0]       oc_r, oc_nxt;
  logic             ol_r, ol_nxt;
  logic [3:0]       on_r, on_nxt;

  logic             advance;
  logic [MAG_W-1:0] pw;
  logic [MAG_W+1:0] thr [10];
  logic [3:0]       digit;
  logic [MAG_W+1:0] sub;

  assign advance = !ov_r || !out_stall;
  assign q_pop   = q_valid && !busy_r;
  assign pw      = pow10(pos_r);

  // Build the multiples of the current power of ten
  always_comb begin
    for (int m = 0; m < 10; m++) begin
      thr[m] = 34'(m) * {2'b00, pw};
    end
  end

  // Pick the digit: the largest multiple not above the remainder
  always_comb begin
    digit = 4'd0;
    sub   = '0;
    for (int m = 1; m < 10; m++) begin
      if ({2'b00, rem_r} >= thr[m]) begin
        digit = 4'(m);
        sub   = thr[m];
      end
    end
  end

  // Sequence one character per cycle while the output is not stalled: sign first, then digits from the top
  always_comb begin
    busy_nxt = busy_r;
    sign_nxt = sign_r;
    rem_nxt  = rem_r;
    pos_nxt  = pos_r;
    cnt_nxt  = cnt_r;
    ov_nxt   = advance ? 1'b0 : ov_r;
    oc_nxt   = oc_r;
    ol_nxt   = ol_r;
    on_nxt   = on_r;
    if (!busy_r) begin
      if (q_valid) begin
        busy_nxt = 1'b1;
        sign_nxt = q_item.neg;
        rem_nxt  = q_item.mag;
        pos_nxt  = q_item.ndig - 4'd1;
        cnt_nxt  = 4'd0;
      end
    end else if (advance) begin
      ov_nxt  = 1'b1;
      on_nxt  = cnt_r + 4'd1;
      cnt_nxt = cnt_r + 4'd1;
      if (sign_r) begin
        oc_nxt   = ASCII_MINUS;
        ol_nxt   = 1'b0;
        sign_nxt = 1'b0;
      end else begin
        oc_nxt  = ASCII_ZERO + {4'd0, digit};
        ol_nxt  = (pos_r == 4'd0);
        rem_nxt = rem_r - sub[MAG_W-1:0];
        pos_nxt = pos_r - 4'd1;
        if (pos_r == 4'd0) begin
          busy_nxt = 1'b0;
          pos_nxt  = 4'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sign_r <= 1'b0;
      pos_r  <= 4'd0;
      cnt_r  <= 4'd0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      sign_r <= sign_nxt;
      pos_r  <= pos_nxt;
      cnt_r  <= cnt_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // Hold the payload registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    oc_r  <= oc_nxt;
    ol_r  <= ol_nxt;
    on_r  <= on_nxt;
  end

  assign out_valid      = ov_r;
  assign out_char_code  = oc_r;
  assign out_last_char  = ol_r;
  assign out_char_count = on_r;

endmodule

FILE: hdl/signed_int_to_decimal_ascii_top.sv
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  in_value[31:0] signed
// out_     output     out_valid/out_stall  out_char_code[7:0], out_last_char,
//                                          out_char_count[3:0]
//
// Each integer is loaded into the digit sequencer in the back part, which then
// emits one character per cycle while the output is not stalled; a two-entry queue
// lets the front take new items while the back is busy.
// Reset (rst_n low, synchronous) empties the queue and drops any output.
// A stalled output holds its character; the sequencer waits with it.
module signed_int_to_decimal_ascii_top
  import sitoa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char_code,
  output logic        out_last_char,
  output logic [3:0]  out_char_count
);

  sitoa_item_t fr_item;
  sitoa_item_t q_item;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  logic        push;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  sitoa_front u_front (
    .in_value (in_value),
    .item     (fr_item)
  );

  sitoa_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (fr_item),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_item)
  );

  sitoa_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_code  (out_char_code),
    .out_last_char  (out_last_char),
    .out_char_count (out_char_count)
  );

endmodule

FILE: hdl/sitoa_checker.sv
module sitoa_checker
  import sitoa_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char_code,
  input logic       out_last_char,
  input logic [3:0] out_char_count
);

  // Hold a stalled item
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char_code)
      && $stable(out_last_char) && $stable(out_char_count))
    else $error("stalled output item changed");

  // Follow a taken non-final character at once with the next one
  a_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_char |=> out_valid
      && out_char_count == $past(out_char_count) + 4'd1)
    else $error("character sequence broke or count skipped");

  // Allow a minus sign only as the first, non-final character
  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_code == ASCII_MINUS |-> out_char_count == 4'd1 && !out_last_char)
    else $error("minus sign out of place");

  // End each number on a digit with a count in range
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_char |-> out_char_code >= ASCII_ZERO
      && out_char_code <= ASCII_ZERO + 8'd9
      && out_char_count >= 4'd1 && out_char_count <= 4'd11)
    else $error("bad final character");

endmodule

bind signed_int_to_decimal_ascii_top sitoa_checker u_sitoa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_char_code  (out_char_code),
  .out_last_char  (out_last_char),
  .out_char_count (out_char_count)
);

FILE: verif/tb_signed_int_to_decimal_ascii_top.sv
`timescale 1ns / 100ps

module tb_signed_int_to_decimal_ascii_top;
  import sitoa_pkg::*;

  localparam int DIR_N      = 20;
  localparam int RAND_ITEMS = 300;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_WAIT = 16;
  localparam int MAX_SHOWN  = 10;

  // One emitted character as seen on the result channel
  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic [3:0] count;
  } char_res_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [31:0] in_value  = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_char_code;
  logic        out_last_char;
  logic [3:0]  out_char_count;

  char_res_t pending_chars[$];

  int n_items     = 0;
  int n_neg       = 0;
  int n_full_len  = 0;
  int n_chars     = 0;
  int n_errors    = 0;
  int idle_cycles = 0;

  logic [31:0] dir_value [DIR_N] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001,
    32'h0000_0009, 32'h0000_000A, 32'hFFFF_FFF6, 32'd999999999, 32'd1000000000,
    32'hC465_3600, 32'hFFFF_FF9C, 32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA,
    32'h0001_E240, 32'hFFFE_1DC0, 32'h0000_0063, 32'h1234_5678, 32'hFEDC_BA98
  };
  // Expected text where it is obvious, empty where the predictor decides
  string dir_text [DIR_N] = '{
    "0", "-2147483648", "2147483647", "-1", "1",
    "9", "10", "-10", "999999999", "1000000000",
    "-1000000000", "-100", "-2147483647", "", "",
    "123456", "-123456", "99", "", ""
  };

  signed_int_to_decimal_ascii_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_code  (out_char_code),
    .out_last_char  (out_last_char),
    .out_char_count (out_char_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Predict the characters of one integer: sign first, then digits MSD first
  function automatic void predict_decimal_chars(input logic [31:0] v);
    logic        neg;
    logic [31:0] mag;
    logic [31:0] rem;
    logic [3:0]  digs [10];
    int          nd;
    int          k;
    char_res_t   c;
    neg = v[31];
    mag = neg ? (32'd0 - v) : v;
    nd  = 0;
    k   = 0;
    do begin
      rem      = mag % 32'd10;
      digs[nd] = rem[3:0];
      mag      = mag / 32'd10;
      nd++;
    end while (mag != 32'd0);
    if (neg) begin
      c.code  = ASCII_MINUS;
      c.last  = 1'b0;
      c.count = 4'(k + 1);
      pending_chars.push_back(c);
      k++;
    end
    for (int i = nd - 1; i >= 0; i--) begin
      c.code  = ASCII_ZERO + {4'd0, digs[i]};
      c.last  = (i == 0);
      c.count = 4'(k + 1);
      pending_chars.push_back(c);
      k++;
    end
  endfunction

  // Queue a known text as the expected characters
  function automatic void expect_text(input string s);
    char_res_t c;
    for (int i = 0; i < s.len(); i++) begin
      c.code  = s[i];
      c.last  = (i == s.len() - 1);
      c.count = 4'(i + 1);
      pending_chars.push_back(c);
    end
  endfunction

  // Present one integer and hold it until accepted; leaves in_valid high
  task automatic send_value(input logic [31:0] v, input string text);
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    if (text.len() > 0) expect_text(text);
    else predict_decimal_chars(v);
    n_items++;
    if (v[31]) n_neg++;
    if (v == 32'h8000_0000) n_full_len++;
  endtask

  // Drop valid for a number of cycles
  task automatic idle_input(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Hold off input until every queued character has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_chars.size() != 0);
  endtask

  // Random integer, mostly with a chosen digit count and sign, sometimes fully random
  function automatic logic [31:0] rand_value();
    int          nd;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] mag;
    logic        neg;
    if ($urandom_range(0, 4) == 0) return $urandom();
    nd  = $urandom_range(1, 10);
    neg = 1'($urandom_range(0, 1));
    lo  = 32'd1;
    for (int i = 1; i < nd; i++) lo = lo * 32'd10;
    if (nd == 10) hi = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else hi = lo * 32'd10 - 32'd1;
    if (nd == 1) lo = 32'd0;
    mag = $urandom_range(hi, lo);
    return neg ? (32'd0 - mag) : mag;
  endfunction

  // Stimulus: reset, directed table, then random bursts
  initial begin
    int burst;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < DIR_N; i++) begin
      send_value(dir_value[i], dir_text[i]);
      if ($urandom_range(0, 2) == 0) idle_input($urandom_range(1, 4));
    end
    wait_drained();
    burst = 0;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      send_value(rand_value(), "");
      burst--;
      if (burst <= 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 15) == 0) wait_drained();
        else if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 15));
      end
    end
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Converted %0d integers (%0d negative, %0d most negative) into %0d characters,",
             n_items, n_neg, n_full_len, n_chars);
    $display("with bursty input and mixed output stalls; %0d mismatches.", n_errors);
    if (n_errors == 0) begin
      $display("tb_signed_int_to_decimal_ascii_top OK");
    end else begin
      $display("tb_signed_int_to_decimal_ascii_top NOT OK");
    end
    $finish;
  end

  // Output stall: switch among free flow, light, heavy and periodic stalling
  int stall_mode  = 0;
  int mode_left   = 100;
  int stall_run   = 0;
  int stall_phase = 0;
  always @(posedge clk) begin
    logic s;
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(64, 256);
    end else begin
      mode_left--;
    end
    stall_phase++;
    case (stall_mode)
      0:       s = 1'b0;
      1:       s = ($urandom_range(0, 3) == 0);
      2:       s = ($urandom_range(0, 9) < 7);
      default: s = (stall_phase % 3 == 0);
    endcase
    // Cap a stall run so every character leaves eventually
    if (s && stall_run >= 8) s = 1'b0;
    stall_run = s ? stall_run + 1 : 0;
    out_stall <= s;
  end

  // Check each accepted character against the oldest expectation
  always @(posedge clk) begin
    char_res_t exp_c;
    if (rst_n && out_valid && !out_stall) begin
      n_chars++;
      if (pending_chars.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_SHOWN)
          $display("%0t: unexpected character code=%0d last=%0b count=%0d",
                   $realtime, out_char_code, out_last_char, out_char_count);
      end else begin
        exp_c = pending_chars.pop_front();
        if (out_char_code !== exp_c.code || out_last_char !== exp_c.last ||
            out_char_count !== exp_c.count) begin
          n_errors++;
          if (n_errors <= MAX_SHOWN)
            $display("%0t: mismatch code %0d/%0d last %0b/%0b count %0d/%0d (exp/act)",
                     $realtime, exp_c.code, out_char_code, exp_c.last, out_last_char,
                     exp_c.count, out_char_count);
        end
      end
    end
  end

  // Watchdog: end the run when no channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d idle cycles, %0d characters still pending",
               idle_cycles, pending_chars.size());
      $display("tb_signed_int_to_decimal_ascii_top NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
